// ===== rtl/triaxial_sensor_autorange_defines.svh =====
// Assertion macros for the triaxial sensor auto-range block.
// Used by the top level only; depends on nothing.
`ifndef TRIAXIAL_SENSOR_AUTORANGE_DEFINES_SVH
`define TRIAXIAL_SENSOR_AUTORANGE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsa assertion failed");

// Next-cycle implication, disabled during reset.
`define TSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsa assertion failed");

`endif

// ===== rtl/tsa_pkg.sv =====
// Shared types and constants for the triaxial sensor auto-range block.
// No dependencies.
package tsa_pkg;

    localparam int RANGE_W    = 2;
    localparam int WORD_W     = 16;
    localparam int MAG_W      = 15;
    localparam int OFFSET_W   = 19;
    localparam int SCALED_W   = 20;
    localparam int THRESH_W   = 15;
    localparam int CFG_DATA_W = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int WR_VALUE_W = 5;

    localparam logic [RANGE_W-1:0] MAX_RANGE = 2'd3;

    localparam logic [THRESH_W-1:0] UPPER_RESET = 15'd16384;
    localparam logic [THRESH_W-1:0] LOWER_RESET = 15'd4096;

    localparam logic [MAG_W-1:0] MAG_MAX = 15'h7fff;

    localparam logic signed [SCALED_W-1:0] SCALED_MAX = 20'sh7ffff;
    localparam logic signed [SCALED_W-1:0] SCALED_MIN = 20'sh80000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER_THRESHOLD = 3'd0,
        CFG_LOWER_THRESHOLD = 3'd1,
        CFG_OFFSET_X        = 3'd2,
        CFG_OFFSET_Y        = 3'd3,
        CFG_OFFSET_Z        = 3'd4
    } cfg_idx_t;

    typedef logic [RANGE_W-1:0] range_t;

    typedef struct packed {
        logic [WORD_W-1:0] x_word;
        logic [WORD_W-1:0] y_word;
        logic [WORD_W-1:0] z_word;
    } in_t;

    typedef struct packed {
        logic signed [SCALED_W-1:0] x_scaled;
        logic signed [SCALED_W-1:0] y_scaled;
        logic signed [SCALED_W-1:0] z_scaled;
        range_t                     scale_used;
        logic                       range_write_valid;
        logic [WR_VALUE_W-1:0]      range_write_value;
    } out_t;

endpackage

// ===== rtl/tsa_axis.sv =====
// One axis datapath: byte swap, peak magnitude, range shift, offset, saturate.
// Depends on tsa_pkg.
module tsa_axis (
    input  logic [tsa_pkg::WORD_W-1:0]          word,
    input  tsa_pkg::range_t                     range,
    input  logic signed [tsa_pkg::OFFSET_W-1:0] offset,
    output logic [tsa_pkg::MAG_W-1:0]           mag,
    output logic signed [tsa_pkg::SCALED_W-1:0] scaled
);

    logic signed [tsa_pkg::WORD_W-1:0]     sample;
    logic [tsa_pkg::WORD_W-1:0]            neg;
    logic signed [tsa_pkg::OFFSET_W-1:0]   ext;
    logic signed [tsa_pkg::OFFSET_W-1:0]   shifted;
    logic signed [tsa_pkg::SCALED_W:0]     diff;

    assign sample = {word[7:0], word[15:8]};

    // most negative sample counts as full-scale positive
    always_comb
    begin
        neg = ~sample + 16'd1;
        if (!sample[tsa_pkg::WORD_W-1])
            mag = sample[tsa_pkg::MAG_W-1:0];
        else if (neg[tsa_pkg::WORD_W-1])
            mag = tsa_pkg::MAG_MAX;
        else
            mag = neg[tsa_pkg::MAG_W-1:0];
    end

    // 16 bits shifted by at most 3 fits 19 bits
    assign ext     = {{3{sample[tsa_pkg::WORD_W-1]}}, sample};
    assign shifted = ext <<< range;
    assign diff    = {{2{shifted[tsa_pkg::OFFSET_W-1]}}, shifted}
                   - {{2{offset[tsa_pkg::OFFSET_W-1]}}, offset};

    always_comb
    begin
        unique case (diff[tsa_pkg::SCALED_W:tsa_pkg::SCALED_W-1])
            2'b01:   scaled = tsa_pkg::SCALED_MAX;
            2'b10:   scaled = tsa_pkg::SCALED_MIN;
            default: scaled = diff[tsa_pkg::SCALED_W-1:0];
        endcase
    end

endmodule

// ===== rtl/triaxial_sensor_autorange.sv =====
// Triaxial sensor auto-range: top level. Depends on tsa_pkg, tsa_axis, defines header.
// Pipeline: input register, then result register.
// Throughput: one sample per clock while out_stall is low; the input register also takes a sample while the result
// register is held, as long as it is empty itself.
// Reset (rst_n, async, active low): range 0, no pending change, thresholds
// 16384/4096, offsets 0, both pipeline registers empty.
`include "triaxial_sensor_autorange_defines.svh"

module triaxial_sensor_autorange (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  tsa_pkg::in_t                       in_data,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output tsa_pkg::out_t                      out_data,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tsa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers
    logic [tsa_pkg::THRESH_W-1:0]        upper_reg;
    logic [tsa_pkg::THRESH_W-1:0]        lower_reg;
    logic signed [tsa_pkg::OFFSET_W-1:0] off_x_reg;
    logic signed [tsa_pkg::OFFSET_W-1:0] off_y_reg;
    logic signed [tsa_pkg::OFFSET_W-1:0] off_z_reg;

    // Range state
    tsa_pkg::range_t chosen_range_reg;
    tsa_pkg::range_t chosen_range_next;
    tsa_pkg::range_t applied_range_reg;
    tsa_pkg::range_t applied_range_next;
    logic            change_pending_reg;
    logic            change_pending_next;

    // Pipeline
    logic            in_valid_reg;
    tsa_pkg::in_t    in_data_reg;
    logic            out_valid_reg;
    tsa_pkg::out_t   out_data_reg;
    tsa_pkg::out_t   out_data_next;
    logic            advance;
    logic            in_load;

    // Per-axis results
    logic [tsa_pkg::MAG_W-1:0]           mag_x, mag_y, mag_z;
    logic [tsa_pkg::MAG_W-1:0]           peak;
    logic signed [tsa_pkg::SCALED_W-1:0] scaled_x, scaled_y, scaled_z;
    tsa_pkg::range_t                     step_range;
    logic                                wr_valid;

    // ------------------------------------------------------------------
    // Handshake: the result slot moves when it is empty or drains; the
    // input register loads when it moves on or is empty.
    // A new sample can enter every cycle while results drain.
    // ------------------------------------------------------------------
    assign advance   = !out_valid_reg || !out_stall;
    assign in_load   = advance || !in_valid_reg;
    assign in_stall  = !in_load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= tsa_pkg::UPPER_RESET;
            lower_reg <= tsa_pkg::LOWER_RESET;
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsa_pkg::CFG_UPPER_THRESHOLD: upper_reg <= cfg_data[tsa_pkg::THRESH_W-1:0];
                tsa_pkg::CFG_LOWER_THRESHOLD: lower_reg <= cfg_data[tsa_pkg::THRESH_W-1:0];
                tsa_pkg::CFG_OFFSET_X:        off_x_reg <= cfg_data;
                tsa_pkg::CFG_OFFSET_Y:        off_y_reg <= cfg_data;
                tsa_pkg::CFG_OFFSET_Z:        off_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Axis datapaths, all scaled with the range currently applied.
    // ------------------------------------------------------------------
    tsa_axis u_axis_x (
        .word   (in_data_reg.x_word),
        .range  (applied_range_reg),
        .offset (off_x_reg),
        .mag    (mag_x),
        .scaled (scaled_x)
    );

    tsa_axis u_axis_y (
        .word   (in_data_reg.y_word),
        .range  (applied_range_reg),
        .offset (off_y_reg),
        .mag    (mag_y),
        .scaled (scaled_y)
    );

    tsa_axis u_axis_z (
        .word   (in_data_reg.z_word),
        .range  (applied_range_reg),
        .offset (off_z_reg),
        .mag    (mag_z),
        .scaled (scaled_z)
    );

    always_comb
    begin
        peak = mag_x;
        if (mag_y > peak)
            peak = mag_y;
        if (mag_z > peak)
            peak = mag_z;
    end

    // ------------------------------------------------------------------
    // Range selector with hysteresis. Step up wins over step down.
    // The sample after a change only commits the new applied range and
    // makes no decision of its own.
    // ------------------------------------------------------------------
    always_comb
    begin
        step_range          = chosen_range_reg;
        chosen_range_next   = chosen_range_reg;
        applied_range_next  = applied_range_reg;
        change_pending_next = change_pending_reg;
        wr_valid            = 1'b0;

        priority if (peak > upper_reg && chosen_range_reg < tsa_pkg::MAX_RANGE)
            step_range = chosen_range_reg + 2'd1;
        else if (peak < lower_reg && chosen_range_reg != '0)
            step_range = chosen_range_reg - 2'd1;
        else
            step_range = chosen_range_reg;

        if (in_valid_reg && advance)
        begin
            if (change_pending_reg)
            begin
                change_pending_next = 1'b0;
                applied_range_next  = chosen_range_reg;
            end
            else if (step_range != chosen_range_reg)
            begin
                wr_valid            = 1'b1;
                chosen_range_next   = step_range;
                change_pending_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_data_next.x_scaled          = scaled_x;
        out_data_next.y_scaled          = scaled_y;
        out_data_next.z_scaled          = scaled_z;
        out_data_next.scale_used        = applied_range_reg;
        out_data_next.range_write_valid = wr_valid;
        out_data_next.range_write_value = wr_valid ? {step_range, 3'b000} : '0;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chosen_range_reg   <= '0;
            applied_range_reg  <= '0;
            change_pending_reg <= 1'b0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            chosen_range_reg   <= chosen_range_next;
            applied_range_reg  <= applied_range_next;
            change_pending_reg <= change_pending_next;
            if (in_load)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
            in_data_reg <= in_data;
        if (advance && in_valid_reg)
            out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TSA_ASSERT_NOW(a_settled_ranges_match, clk, rst_n,
        !change_pending_reg, applied_range_reg == chosen_range_reg)
    `TSA_ASSERT_NOW(a_pending_ranges_differ, clk, rst_n,
        change_pending_reg, applied_range_reg != chosen_range_reg)
    `TSA_ASSERT_NOW(a_write_matches_choice, clk, rst_n,
        out_valid_reg && out_data_reg.range_write_valid,
        change_pending_reg
            && out_data_reg.range_write_value[tsa_pkg::WR_VALUE_W-1:3] == chosen_range_reg
            && out_data_reg.range_write_value[2:0] == 3'b000)
    `TSA_ASSERT_NOW(a_no_write_zero_value, clk, rst_n,
        out_valid_reg && !out_data_reg.range_write_valid,
        out_data_reg.range_write_value == '0)
    `TSA_ASSERT_NEXT(a_pending_clears, clk, rst_n,
        in_valid_reg && advance && change_pending_reg, !change_pending_reg)

endmodule

// ===== tb/triaxial_sensor_autorange_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the triaxial sensor auto-range block: directed rows, then random phases.
// Depends on tsa_pkg and triaxial_sensor_autorange from the rtl folder.
module triaxial_sensor_autorange_test;

    localparam int PIPE_LATENCY     = 2;       // input reg + result reg
    localparam int LONG_HOLD        = 300;     // long receiver hold-off, in cycles
    localparam int RANDOM_PER_PHASE = 240;     // five phases, about 1200 samples
    localparam int CYCLE_LIMIT      = 400000;

    // Indexes past the end of the register list; writes there are ignored
    localparam logic [tsa_pkg::CFG_IDX_W-1:0] IDX_PAST_LIST = 3'd5;

    localparam logic [tsa_pkg::OFFSET_W-1:0] OFFSET_TOP    = 19'h3ffff;
    localparam logic [tsa_pkg::OFFSET_W-1:0] OFFSET_BOTTOM = 19'h40000;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        tsa_pkg::in_t                    smp;
        bit                              typed;
        tsa_pkg::out_t                   want;
        logic [tsa_pkg::CFG_IDX_W-1:0]   idx;
        logic [tsa_pkg::CFG_DATA_W-1:0]  data;
    } stim_row_t;

    // Travels with each offered sample: a hand-typed result, if the row has one
    typedef struct {
        bit            typed;
        tsa_pkg::out_t want;
    } sample_tag_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    tsa_pkg::in_t                   in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    tsa_pkg::out_t                  out_data;
    logic                           cfg_we = 1'b0;
    logic [tsa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tsa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    triaxial_sensor_autorange u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Range tracker: own copy of the registers and of the hysteresis state
    // ------------------------------------------------------------------
    logic [tsa_pkg::THRESH_W-1:0]        up_thr;
    logic [tsa_pkg::THRESH_W-1:0]        low_thr;
    logic signed [tsa_pkg::OFFSET_W-1:0] axis_off [3];
    tsa_pkg::range_t                     sel_range;      // range the selector has settled on
    bit                                  switch_pending; // rewrite issued, scale not yet moved
    tsa_pkg::range_t                     live_range;     // range the scaling uses now

    sample_tag_t   sample_tags_q [$];
    tsa_pkg::out_t pending_results_q [$];
    stim_row_t     stim_rows [$];

    int fail_count   = 0;
    int result_count = 0;
    int cycle_count  = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold_req = 1'b0;

    function automatic logic [tsa_pkg::WORD_W-1:0] to_bus(logic [tsa_pkg::WORD_W-1:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    // -32768 has no positive twin; it counts as full scale
    function automatic logic [tsa_pkg::MAG_W-1:0] magnitude_of(
        logic signed [tsa_pkg::WORD_W-1:0] v);
        logic signed [tsa_pkg::WORD_W:0] t;
        if (v == 16'sh8000)
            return tsa_pkg::MAG_MAX;
        t = v;
        if (t < 0)
            t = -t;
        return t[tsa_pkg::MAG_W-1:0];
    endfunction

    function automatic logic signed [tsa_pkg::SCALED_W-1:0] rescale(
        logic signed [tsa_pkg::WORD_W-1:0] v,
        logic signed [tsa_pkg::OFFSET_W-1:0] off,
        tsa_pkg::range_t r);
        logic signed [23:0] wide;
        wide = v;
        wide = wide <<< r;
        wide = wide - off;
        if (wide > tsa_pkg::SCALED_MAX)
            wide = tsa_pkg::SCALED_MAX;
        if (wide < tsa_pkg::SCALED_MIN)
            wide = tsa_pkg::SCALED_MIN;
        return wide[tsa_pkg::SCALED_W-1:0];
    endfunction

    function automatic void apply_reg(logic [tsa_pkg::CFG_IDX_W-1:0] idx,
                                      logic [tsa_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tsa_pkg::CFG_UPPER_THRESHOLD: up_thr = data[tsa_pkg::THRESH_W-1:0];
            tsa_pkg::CFG_LOWER_THRESHOLD: low_thr = data[tsa_pkg::THRESH_W-1:0];
            tsa_pkg::CFG_OFFSET_X:        axis_off[0] = data;
            tsa_pkg::CFG_OFFSET_Y:        axis_off[1] = data;
            tsa_pkg::CFG_OFFSET_Z:        axis_off[2] = data;
            default:                      ;
        endcase
    endfunction

    // Result of one sample, advancing the selector state
    function automatic tsa_pkg::out_t track_sample(tsa_pkg::in_t s);
        logic signed [tsa_pkg::WORD_W-1:0] ax [3];
        logic [tsa_pkg::MAG_W-1:0]         peak;
        tsa_pkg::range_t                   nxt;
        tsa_pkg::out_t                     r;
        int                                i;
        ax[0] = to_bus(s.x_word);
        ax[1] = to_bus(s.y_word);
        ax[2] = to_bus(s.z_word);
        peak = '0;
        for (i = 0; i < 3; i++)
            if (magnitude_of(ax[i]) > peak)
                peak = magnitude_of(ax[i]);
        r.x_scaled          = rescale(ax[0], axis_off[0], live_range);
        r.y_scaled          = rescale(ax[1], axis_off[1], live_range);
        r.z_scaled          = rescale(ax[2], axis_off[2], live_range);
        r.scale_used        = live_range;
        r.range_write_valid = 1'b0;
        r.range_write_value = '0;
        if (switch_pending)
        begin
            // sample straight after a change: old scale, no decision
            switch_pending = 1'b0;
            live_range     = sel_range;
        end
        else
        begin
            nxt = sel_range;
            // going up wins when both thresholds are crossed
            if (peak > up_thr && sel_range < tsa_pkg::MAX_RANGE)
                nxt = sel_range + 1'b1;
            else if (peak < low_thr && sel_range != '0)
                nxt = sel_range - 1'b1;
            if (nxt != sel_range)
            begin
                r.range_write_valid = 1'b1;
                r.range_write_value = {nxt, 3'b000};
                sel_range           = nxt;
                switch_pending      = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        fail_count++;
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 result_count, what, got, want);
    endtask

    sample_tag_t   mon_tag;
    tsa_pkg::out_t mon_pred;
    tsa_pkg::out_t mon_want;

    // Sampled at the edge, before any of this edge's nonblocking updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && in_stall === 1'b0)
            begin
                mon_tag  = sample_tags_q.pop_front();
                mon_pred = track_sample(in_data);
                pending_results_q.push_back(mon_tag.typed ? mon_tag.want : mon_pred);
            end
            if (out_valid === 1'b1 && !out_stall)
            begin
                if (pending_results_q.size() == 0)
                    report_mismatch("transfer with nothing pending", 0, 0);
                else
                begin
                    mon_want = pending_results_q.pop_front();
                    if (out_data.x_scaled !== mon_want.x_scaled)
                        report_mismatch("x_scaled", out_data.x_scaled, mon_want.x_scaled);
                    if (out_data.y_scaled !== mon_want.y_scaled)
                        report_mismatch("y_scaled", out_data.y_scaled, mon_want.y_scaled);
                    if (out_data.z_scaled !== mon_want.z_scaled)
                        report_mismatch("z_scaled", out_data.z_scaled, mon_want.z_scaled);
                    if (out_data.scale_used !== mon_want.scale_used)
                        report_mismatch("scale_used", out_data.scale_used,
                                        mon_want.scale_used);
                    if (out_data.range_write_valid !== mon_want.range_write_valid)
                        report_mismatch("range_write_valid", out_data.range_write_valid,
                                        mon_want.range_write_valid);
                    if (out_data.range_write_value !== mon_want.range_write_value)
                        report_mismatch("range_write_value", out_data.range_write_value,
                                        mon_want.range_write_value);
                end
                result_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, or one long hold-off when asked
    // ------------------------------------------------------------------
    initial
    begin : stall_receiver
        int held;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                // block fills up (two stages) and must push back on the sender
                for (held = 0; held < LONG_HOLD; held++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Returns at the edge of the transfer, with no assignment made in that step
    task automatic send_sample(tsa_pkg::in_t s, bit typed, tsa_pkg::out_t want);
        sample_tag_t tag;
        tag.typed = typed;
        tag.want  = want;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        sample_tags_q.push_back(tag);
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // Nothing in flight, then a margin beyond the pipeline depth
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results_q.size() != 0 || sample_tags_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [tsa_pkg::CFG_IDX_W-1:0] idx,
                             logic [tsa_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random axis word; trend 0 leans loud, 1 leans quiet, 2 mixes
    function automatic logic [tsa_pkg::WORD_W-1:0] rand_axis(int trend);
        logic [tsa_pkg::MAG_W-1:0]  m;
        logic [tsa_pkg::WORD_W-1:0] v;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            v = 16'h8000;
        else if (pick < 10)
            v = 16'h7fff;
        else if (pick < 15)
            v = '0;
        else if (pick < 35)
            v = 16'($urandom());
        else
        begin
            if (trend == 0 || (trend == 2 && pick < 65))
                m = 15'($urandom_range(up_thr, 32767));
            else
                m = (low_thr == '0) ? '0 : 15'($urandom_range(0, low_thr - 1));
            v = {1'b0, m};
            if ($urandom_range(0, 1))
                v = -v;
        end
        return to_bus(v);
    endfunction

    // ------------------------------------------------------------------
    // Directed rows
    // ------------------------------------------------------------------
    task automatic add_sample(int x, int y, int z);
        stim_row_t row;
        row.kind        = ROW_SAMPLE;
        row.smp.x_word  = to_bus(x[15:0]);
        row.smp.y_word  = to_bus(y[15:0]);
        row.smp.z_word  = to_bus(z[15:0]);
        row.typed       = 1'b0;
        row.want        = '0;
        row.idx         = '0;
        row.data        = '0;
        stim_rows.push_back(row);
    endtask

    task automatic add_known(int x, int y, int z, int xs, int ys, int zs,
                             int sc, int wv, int wval);
        stim_row_t row;
        row.kind                   = ROW_SAMPLE;
        row.smp.x_word             = to_bus(x[15:0]);
        row.smp.y_word             = to_bus(y[15:0]);
        row.smp.z_word             = to_bus(z[15:0]);
        row.typed                  = 1'b1;
        row.want.x_scaled          = xs[tsa_pkg::SCALED_W-1:0];
        row.want.y_scaled          = ys[tsa_pkg::SCALED_W-1:0];
        row.want.z_scaled          = zs[tsa_pkg::SCALED_W-1:0];
        row.want.scale_used        = sc[tsa_pkg::RANGE_W-1:0];
        row.want.range_write_valid = wv[0];
        row.want.range_write_value = wval[tsa_pkg::WR_VALUE_W-1:0];
        row.idx                    = '0;
        row.data                   = '0;
        stim_rows.push_back(row);
    endtask

    task automatic add_reg(logic [tsa_pkg::CFG_IDX_W-1:0] idx,
                           logic [tsa_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind  = ROW_CFG;
        row.smp   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        row.idx   = idx;
        row.data  = data;
        stim_rows.push_back(row);
    endtask

    initial
    begin : main_sequence
        tsa_pkg::in_t                 smp;
        logic [tsa_pkg::THRESH_W-1:0] lo;
        logic [tsa_pkg::THRESH_W-1:0] hi;
        int                           ph;
        int                           n;
        int                           trend;

        up_thr         = tsa_pkg::UPPER_RESET;
        low_thr        = tsa_pkg::LOWER_RESET;
        axis_off[0]    = '0;
        axis_off[1]    = '0;
        axis_off[2]    = '0;
        sel_range      = '0;
        switch_pending = 1'b0;
        live_range     = '0;

        // Reset thresholds 16384 / 4096, offsets 0: every result is easy to work out
        add_known(0, 0, 0,                  0, 0, 0,                   0, 0, 0);
        // full scale and most negative: peak 32767, step up to 1
        add_known(32767, -32768, 1,         32767, -32768, 1,          0, 1, 8);
        // pending step: old scale, no decision
        add_known(32767, 32767, 32767,      32767, 32767, 32767,       0, 0, 0);
        add_known(32767, -32768, 0,         65534, -65536, 0,          1, 1, 16);
        add_known(-32768, -32768, -32768,   -65536, -65536, -65536,    1, 0, 0);
        add_known(-32768, 32767, 100,       -131072, 131068, 400,      2, 1, 24);
        add_known(32767, 32767, 32767,      131068, 131068, 131068,    2, 0, 0);
        // top range: loud sample cannot step further up
        add_known(32767, -32768, 32767,     262136, -262144, 262136,   3, 0, 0);
        // quiet run back down to 0
        add_known(0, 0, 0,                  0, 0, 0,                   3, 1, 16);
        add_known(1, -1, 0,                 8, -8, 0,                  3, 0, 0);
        add_known(0, 0, 0,                  0, 0, 0,                   2, 1, 8);
        add_known(0, 0, 0,                  0, 0, 0,                   2, 0, 0);
        // write of range 0: valid set, value zero
        add_known(0, 0, 0,                  0, 0, 0,                   1, 1, 0);
        add_known(0, 0, 0,                  0, 0, 0,                   1, 0, 0);
        // exactly on the upper threshold: inside the band, no change
        add_known(16384, -4096, 0,          16384, -4096, 0,           0, 0, 0);
        add_known(16385, 0, 0,              16385, 0, 0,               0, 1, 8);
        add_known(4095, 0, 0,               4095, 0, 0,                0, 0, 0);
        add_known(4095, 0, -4095,           8190, 0, -8190,            1, 1, 0);
        // extreme offsets, both thresholds crossed at once, ignored index
        add_reg(tsa_pkg::CFG_OFFSET_X, OFFSET_TOP);
        add_reg(tsa_pkg::CFG_OFFSET_Y, OFFSET_BOTTOM);
        add_reg(tsa_pkg::CFG_OFFSET_Z, 19'd1);
        add_reg(tsa_pkg::CFG_UPPER_THRESHOLD, '0);
        add_reg(tsa_pkg::CFG_LOWER_THRESHOLD, 19'h07fff);
        add_reg(IDX_PAST_LIST, 19'h7ffff);
        add_sample(-32768, 32767, 0);
        add_sample(5, -5, 0);
        add_sample(0, 0, 0);
        add_sample(1, 1, 1);
        add_sample(7, 0, 0);
        add_sample(100, -100, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 20;
        recv_stall_pct = 20;
        foreach (stim_rows[k])
        begin
            if (stim_rows[k].kind == ROW_CFG)
            begin
                wait_for_quiet();
                write_reg(stim_rows[k].idx, stim_rows[k].data);
            end
            else
                send_sample(stim_rows[k].smp, stim_rows[k].typed, stim_rows[k].want);
        end

        // Random phases: no idling, sender idle, receiver stalling, both, long hold-off
        for (ph = 0; ph < 5; ph++)
        begin
            wait_for_quiet();
            if ($urandom_range(0, 3) == 0)
            begin
                lo = $urandom_range(0, 1) ? 15'h7fff : 15'h0000;
                hi = $urandom_range(0, 1) ? 15'h7fff : 15'h0000;
            end
            else
            begin
                lo = 15'($urandom_range(256, 12000));
                hi = 15'(lo + $urandom_range(1024, 20000));
            end
            // spare upper data bits are set at random; they must be dropped
            write_reg(tsa_pkg::CFG_UPPER_THRESHOLD, {4'($urandom()), hi});
            write_reg(tsa_pkg::CFG_LOWER_THRESHOLD, {4'($urandom()), lo});
            write_reg(tsa_pkg::CFG_OFFSET_X, ($urandom_range(0, 3) == 0) ?
                      ($urandom_range(0, 1) ? OFFSET_TOP : OFFSET_BOTTOM) : 19'($urandom()));
            write_reg(tsa_pkg::CFG_OFFSET_Y, ($urandom_range(0, 3) == 0) ?
                      ($urandom_range(0, 1) ? OFFSET_TOP : OFFSET_BOTTOM) : 19'($urandom()));
            write_reg(tsa_pkg::CFG_OFFSET_Z, ($urandom_range(0, 3) == 0) ?
                      ($urandom_range(0, 1) ? OFFSET_TOP : OFFSET_BOTTOM) : 19'($urandom()));
            write_reg(IDX_PAST_LIST + 3'($urandom_range(0, 2)), 19'($urandom()));

            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                3: begin send_idle_pct = 32; recv_stall_pct = 32; end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 10;
                    long_hold_req  = 1'b1;
                end
            endcase

            trend = 0;
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // runs of loud or quiet samples walk the range up and down
                if (n % 16 == 0)
                    trend = $urandom_range(0, 2);
                smp.x_word = rand_axis(trend);
                smp.y_word = rand_axis(trend);
                smp.z_word = rand_axis(trend);
                send_sample(smp, 1'b0, '0);
            end
        end

        wait_for_quiet();
        if (fail_count == 0 && pending_results_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tsa_pkg.sv
rtl/tsa_axis.sv
rtl/triaxial_sensor_autorange.sv
tb/triaxial_sensor_autorange_test.sv
